FILE: hw/rtl/spt_pkg.sv
// Shared types and constants for the sorted pair table.
package spt_pkg;

	localparam int TableDepth  = 64;
	localparam int LinearLimit = 16;
	localparam int AddrW  = $clog2(TableDepth);
	localparam int CountW = $clog2(TableDepth + 1);

	typedef enum logic [1:0] {
		OP_CLEAR   = 2'd0,
		OP_APPEND  = 2'd1,
		OP_PREPARE = 2'd2,
		OP_LOOKUP  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_NOT_FOUND  = 2'd1,
		ST_FULL       = 2'd2,
		ST_NOT_SORTED = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		MS_NONE,
		MS_READ,
		MS_WRITE_ITEM,
		MS_WRITE_SHIFT
	} mem_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic              mem_rd;
		logic [AddrW-1:0]  rd_addr;
		logic              mem_wr;
		logic [AddrW-1:0]  wr_addr;
		mem_sel_t          wr_sel;
		logic              hold_item;
		logic              latch_gap;
	} dp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic rd_greater;
		logic rd_equal;
	} dp_stat_t;

endpackage

FILE: hw/rtl/sorted_pair_table.sv
// Top level of the sorted pair table.
// Usage: raise start with operation, pair_key and pair_value while busy is low;
// the command transfers on that edge, and for multi-cycle commands busy is high
// from the next cycle until the result.
// Each command gives one result: done pulses for one cycle with status,
// found_value and entries_held. The receiver cannot stall; results are
// taken at the edge ending the done cycle.
// Clear, append to a full table, prepare of at most 16 entries and lookup in an
// unsorted table of over 16 entries finish without raising busy; lookups of up to
// 16 entries scan linearly, larger sorted tables use binary search.
// The memory has one read and one write port; each step of scan, search or
// sort is a read state followed by a compare state.
// Reset empties the table and marks it sorted; memory contents are not cleared.
module sorted_pair_table import spt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         operation,
	input  logic signed [31:0] pair_key,
	input  logic signed [31:0] pair_value,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] found_value,
	output logic [6:0]         entries_held
);

	dp_cmd_t            cmd;
	dp_stat_t           stat;
	logic signed [31:0] rd_value;

	spt_ctrl u_ctrl (
		.clk, .arst_n, .start, .operation, .busy, .cmd, .stat, .rd_value,
		.done, .status, .found_value, .entries_held
	);

	spt_datapath u_dp (
		.clk, .cmd, .in_key(pair_key), .in_value(pair_value), .stat,
		.rd_value
	);

endmodule

FILE: hw/rtl/spt_datapath.sv
// Key and value memories, held item and key comparators.
module spt_datapath import spt_pkg::*; (
	input  logic                clk,
	input  dp_cmd_t             cmd,
	input  logic signed [31:0]  in_key,
	input  logic signed [31:0]  in_value,
	output dp_stat_t            stat,
	output logic signed [31:0]  rd_value
);

	logic [31:0] key_mem [TableDepth];
	logic [31:0] val_mem [TableDepth];
	logic [31:0] rd_key_q, rd_val_q;
	logic [31:0] item_key_q, item_val_q;
	logic [31:0] wr_k, wr_v;

	always_comb begin
		if (cmd.wr_sel == MS_WRITE_SHIFT) begin
			wr_k = rd_key_q;
			wr_v = rd_val_q;
		end else begin
			wr_k = item_key_q;
			wr_v = item_val_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr) begin
			key_mem[cmd.wr_addr] <= wr_k;
			val_mem[cmd.wr_addr] <= wr_v;
		end
		if (cmd.mem_rd) begin
			rd_key_q <= key_mem[cmd.rd_addr];
			rd_val_q <= val_mem[cmd.rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.hold_item) begin
			item_key_q <= in_key;
			item_val_q <= in_value;
		end else if (cmd.latch_gap) begin
			item_key_q <= rd_key_q;
			item_val_q <= rd_val_q;
		end
	end

	assign stat.rd_greater = $signed(rd_key_q) > $signed(item_key_q);
	assign stat.rd_equal   = rd_key_q == item_key_q;
	assign rd_value = rd_val_q;

endmodule

FILE: hw/rtl/spt_ctrl.sv
// Operation sequencer: clear, append, Shell sort, linear scan and binary search.
module spt_ctrl import spt_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [1:0]         operation,
	output logic               busy,
	output dp_cmd_t            cmd,
	input  dp_stat_t           stat,
	input  logic signed [31:0] rd_value,
	output logic               done,
	output logic [1:0]         status,
	output logic signed [31:0] found_value,
	output logic [6:0]         entries_held
);

	typedef enum logic [3:0] {
		S_IDLE, S_LIN_RD, S_LIN_CMP, S_BIN_RD, S_BIN_CMP,
		S_GAP, S_I_RD, S_I_LATCH, S_J_RD, S_J_CMP, S_PLACE
	} state_t;

	localparam int IdxW = AddrW + 1;

	state_t              state_q;
	logic [CountW-1:0]   count_q;
	logic                sorted_q;
	logic                sorting;
	logic [IdxW-1:0]     idx_q, lo_q, hi_q, mid_q, gap_q, i_q, j_q;
	logic [IdxW-1:0]     mid_c, gap_init, gap_prev;

	assign mid_c = IdxW'((({1'b0, lo_q} + {1'b0, hi_q}) >> 1));
	assign entries_held = 7'(count_q);
	assign busy = state_q != S_IDLE;

	// first gap in 1,4,13,... greater than (n-1)/9
	always_comb begin
		int g;
		g = 1;
		for (int k = 0; k < 4; k++)
			if (g * 9 <= int'(count_q) - 1) g = g * 3 + 1;
		gap_init = IdxW'(g);
	end

	// previous gap in 1,4,13,...; zero after gap 1
	always_comb begin
		int g;
		gap_prev = '0;
		g = 1;
		for (int k = 0; k < 4; k++) begin
			if (IdxW'(g * 3 + 1) == gap_q) gap_prev = IdxW'(g);
			g = g * 3 + 1;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.wr_sel = MS_NONE;
		unique case (state_q)
			S_IDLE: cmd.hold_item = start;
			S_LIN_RD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_addr = AddrW'(idx_q);
			end
			S_BIN_RD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_addr = AddrW'(mid_c);
			end
			S_I_RD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_addr = AddrW'(i_q);
			end
			S_I_LATCH: cmd.latch_gap = 1'b1;
			S_J_RD: begin
				cmd.mem_rd = 1'b1;
				cmd.rd_addr = AddrW'(j_q - gap_q);
			end
			S_J_CMP: if (stat.rd_greater) begin
				cmd.mem_wr = 1'b1;
				cmd.wr_addr = AddrW'(j_q);
				cmd.wr_sel = MS_WRITE_SHIFT;
			end
			S_PLACE: begin
				cmd.mem_wr = 1'b1;
				cmd.wr_addr = AddrW'(j_q);
				cmd.wr_sel = MS_WRITE_ITEM;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			sorted_q <= 1'b1;
			done <= 1'b0;
			status <= ST_OK;
			found_value <= '0;
			idx_q <= '0; lo_q <= '0; hi_q <= '0; mid_q <= '0;
			gap_q <= '0; i_q <= '0; j_q <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: if (start) begin
					found_value <= '0;
					status <= ST_OK;
					unique case (op_t'(operation))
						OP_CLEAR: begin
							count_q <= '0; sorted_q <= 1'b1; done <= 1'b1;
						end
						OP_APPEND: begin
							if (count_q >= CountW'(TableDepth)) begin
								status <= ST_FULL; done <= 1'b1;
							end else begin
								state_q <= S_PLACE;
								j_q <= IdxW'(count_q);
							end
						end
						OP_PREPARE: begin
							if (count_q > CountW'(LinearLimit)) begin
								gap_q <= gap_init;
								state_q <= S_GAP;
							end else done <= 1'b1;
						end
						OP_LOOKUP: begin
							if (count_q <= CountW'(LinearLimit)) begin
								idx_q <= '0;
								state_q <= S_LIN_RD;
							end else if (!sorted_q) begin
								status <= ST_NOT_SORTED; done <= 1'b1;
							end else begin
								lo_q <= '0; hi_q <= IdxW'(count_q);
								state_q <= S_BIN_RD;
							end
						end
						default: ;
					endcase
				end
				S_LIN_RD: begin
					if (idx_q >= IdxW'(count_q)) begin
						status <= ST_NOT_FOUND; done <= 1'b1; state_q <= S_IDLE;
					end else state_q <= S_LIN_CMP;
				end
				S_LIN_CMP: begin
					if (stat.rd_equal) begin
						found_value <= rd_value; done <= 1'b1; state_q <= S_IDLE;
					end else begin
						idx_q <= idx_q + 1'b1; state_q <= S_LIN_RD;
					end
				end
				S_BIN_RD: begin
					if (lo_q == hi_q) begin
						status <= ST_NOT_FOUND; done <= 1'b1; state_q <= S_IDLE;
					end else begin
						mid_q <= mid_c; state_q <= S_BIN_CMP;
					end
				end
				S_BIN_CMP: begin
					// read key greater than item: go low
					if (stat.rd_equal) begin
						found_value <= rd_value; done <= 1'b1; state_q <= S_IDLE;
					end else if (stat.rd_greater) begin
						hi_q <= mid_q; state_q <= S_BIN_RD;
					end else begin
						lo_q <= mid_q + 1'b1; state_q <= S_BIN_RD;
					end
				end
				S_GAP: begin
					if (gap_q == '0) begin
						sorted_q <= 1'b1; done <= 1'b1; state_q <= S_IDLE;
					end else begin
						i_q <= gap_q; state_q <= S_I_RD;
					end
				end
				S_I_RD: begin
					if (i_q >= IdxW'(count_q)) begin
						gap_q <= gap_prev; state_q <= S_GAP;
					end else state_q <= S_I_LATCH;
				end
				S_I_LATCH: begin
					j_q <= i_q; state_q <= S_J_RD;
				end
				S_J_RD: begin
					if (j_q < gap_q) state_q <= S_PLACE;
					else state_q <= S_J_CMP;
				end
				S_J_CMP: begin
					if (stat.rd_greater) begin
						j_q <= j_q - gap_q; state_q <= S_J_RD;
					end else state_q <= S_PLACE;
				end
				S_PLACE: begin
					if (!sorting) begin
						count_q <= count_q + 1'b1; sorted_q <= 1'b0;
						done <= 1'b1; state_q <= S_IDLE;
					end else begin
						i_q <= i_q + 1'b1; state_q <= S_I_RD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) sorting <= 1'b0;
		else if (state_q == S_IDLE && start) sorting <= operation == OP_PREPARE;
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CountW'(TableDepth)) else $error("count overflow");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> state_q == S_IDLE) else $error("done while busy");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_OK |-> found_value == '0) else $error("stale value");
	a_bin_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_BIN_RD |-> lo_q <= hi_q) else $error("bad range");

endmodule
